### rtl/core/ssc_pkg.sv
// shared constants, types and helper functions of the silhouette score engine
package ssc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 64;
    localparam int PT_W         = $clog2(MAX_POINTS);
    localparam int CL_W         = $clog2(MAX_CLUSTERS);
    localparam int CNT_W        = 11;
    localparam int SUM_W        = 26;
    localparam int TOT_W        = 27;
    localparam int SIM_W        = 16;
    localparam int Q_W          = 16;
    localparam int FRAC_W       = 15;
    localparam int DVD_W        = SUM_W + FRAC_W;
    localparam int DVS_W        = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DVD_W);

    localparam logic [SIM_W-1:0] ONE_Q15 = SIM_W'(32768);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_LABEL  = 2'd1;
    localparam logic [1:0] ACT_ENTRY  = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    localparam logic [1:0] ST_NORMAL   = 2'd0;
    localparam logic [1:0] ST_SINGLE   = 2'd1;
    localparam logic [1:0] ST_NO_OTHER = 2'd2;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_MEAN  = 1'b1;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_SWEEP,
        OP_RD_ROW,
        OP_RD_COL,
        OP_RD_OLD,
        OP_DEC,
        OP_RD_NEW,
        OP_INC,
        OP_RD_SUM,
        OP_ADD,
        OP_RD_OWN,
        OP_PCHK,
        OP_ADIV,
        OP_RD_K,
        OP_KCHK,
        OP_KDIV,
        OP_KINC,
        OP_BCHK,
        OP_SDIV,
        OP_EMIT,
        OP_FST,
        OP_FDIV
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic       sweep_last;
        logic [1:0] act;
        logic       row_end;
        logic       own_flag;
        logic       single;
        logic       k_use;
        logic       k_last;
        logic       have_b;
        logic       m_zero;
        logic       div_done;
    } stat_t;

    // truncated quotient magnitude with sign, clipped to signed q1.15
    function automatic logic signed [Q_W-1:0] sat_q15(input logic neg,
                                                       input logic [DVD_W-1:0] mag);
        logic signed [Q_W-1:0] r;
        if (neg)
        begin
            if (mag >= DVD_W'(32768))
                r = 16'sh8000;
            else
                r = $signed(Q_W'(~mag[Q_W-1:0] + 1'b1));
        end
        else
        begin
            if (mag > DVD_W'(32767))
                r = 16'sh7FFF;
            else
                r = $signed(mag[Q_W-1:0]);
        end
        return r;
    endfunction

endpackage

### rtl/core/ssc_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module ssc_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ssc_pkg::DVD_W-1:0] dividend,
    input  logic [ssc_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [ssc_pkg::DVD_W-1:0] quotient
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [ssc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ssc_pkg::DVD_W-1:0]     q_reg, q_next;
    logic [ssc_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [ssc_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [ssc_pkg::DVS_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, q_reg[ssc_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[ssc_pkg::DVD_W-2:0], fits};
            rem_next = fits ? ssc_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[ssc_pkg::DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ssc_pkg::DIV_CNT_W'(ssc_pkg::DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/core/ssc_datapath.sv
// datapath: point and cluster memories, accumulators, divider and result registers
module ssc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssc_pkg::cmd_t                     cmd,
    output ssc_pkg::stat_t                    stat,
    input  logic [1:0]                        action,
    input  logic [ssc_pkg::PT_W-1:0]          row_point,
    input  logic [ssc_pkg::PT_W-1:0]          column_point,
    input  logic [ssc_pkg::CL_W-1:0]          cluster_label,
    input  logic [ssc_pkg::SIM_W-1:0]         similarity,
    input  logic                              row_end,
    input  logic                              cfg_we,
    input  logic [ssc_pkg::CNT_W-1:0]         cfg_data,
    output logic                              result_valid,
    output logic                              result_kind,
    output logic [ssc_pkg::PT_W-1:0]          point_index,
    output logic signed [ssc_pkg::Q_W-1:0]    score,
    output logic [1:0]                        status
);

    localparam int NP = ssc_pkg::MAX_POINTS;
    localparam int NC = ssc_pkg::MAX_CLUSTERS;

    // memories
    logic [ssc_pkg::CL_W-1:0]  label_mem [NP];
    logic                      flag_mem  [NP];
    logic [ssc_pkg::CNT_W-1:0] cnt_mem   [NC];
    logic [ssc_pkg::SUM_W-1:0] sum_mem   [NC];

    // latched item
    logic [1:0]                act_reg, act_next;
    logic [ssc_pkg::PT_W-1:0]  row_reg, row_next;
    logic [ssc_pkg::PT_W-1:0]  col_reg, col_next;
    logic [ssc_pkg::CL_W-1:0]  lab_reg, lab_next;
    logic [ssc_pkg::SIM_W-1:0] sim_reg, sim_next;
    logic                      rend_reg, rend_next;

    // memory read data
    logic                      flag_rd_reg;
    logic [ssc_pkg::CL_W-1:0]  lab_rd_reg;
    logic [ssc_pkg::CNT_W-1:0] cnt_rd_reg;
    logic [ssc_pkg::SUM_W-1:0] sum_rd_reg;
    logic                      sv_rd_reg;

    logic [ssc_pkg::PT_W-1:0]  sweep_reg, sweep_next;
    logic [ssc_pkg::CL_W-1:0]  k_reg, k_next;
    logic [NC-1:0]             sv_reg, sv_next;
    logic [ssc_pkg::SUM_W-1:0] a_reg, a_next;
    logic [ssc_pkg::SUM_W-1:0] b_reg, b_next;
    logic                      have_b_reg, have_b_next;
    logic                      neg_reg, neg_next;
    logic [1:0]                pstat_reg, pstat_next;
    logic signed [ssc_pkg::Q_W-1:0] score_reg, score_next;
    logic signed [ssc_pkg::TOT_W-1:0] total_reg, total_next;
    logic [ssc_pkg::CNT_W-1:0] np_reg, np_next;

    logic                      res_valid_reg, res_valid_next;
    logic                      res_kind_reg, res_kind_next;
    logic [ssc_pkg::PT_W-1:0]  res_idx_reg, res_idx_next;
    logic signed [ssc_pkg::Q_W-1:0] res_score_reg, res_score_next;
    logic [1:0]                res_stat_reg, res_stat_next;

    // memory control
    logic                      pt_re;
    logic [ssc_pkg::PT_W-1:0]  pt_raddr;
    logic                      flag_we, flag_wdata;
    logic [ssc_pkg::PT_W-1:0]  flag_waddr;
    logic                      lab_we;
    logic                      cl_re;
    logic [ssc_pkg::CL_W-1:0]  cl_raddr;
    logic                      cnt_we;
    logic [ssc_pkg::CL_W-1:0]  cnt_waddr;
    logic [ssc_pkg::CNT_W-1:0] cnt_wdata;
    logic                      sum_we;
    logic [ssc_pkg::SUM_W-1:0] sum_wdata;

    // divider
    logic                      div_start;
    logic [ssc_pkg::DVD_W-1:0] div_dvd;
    logic [ssc_pkg::DVS_W-1:0] div_dvs;
    logic                      div_done;
    logic [ssc_pkg::DVD_W-1:0] div_q;

    // helpers
    logic [ssc_pkg::SUM_W-1:0] sum_val;
    logic [ssc_pkg::SIM_W-1:0] dist_q;
    logic [ssc_pkg::SUM_W:0]   sum_add;
    logic                      entry_ok;
    logic                      single;
    logic                      k_use;
    logic [ssc_pkg::SUM_W-1:0] m_val;
    logic [ssc_pkg::SUM_W-1:0] diff;
    logic [ssc_pkg::TOT_W-1:0] total_mag;
    logic [ssc_pkg::CNT_W-1:0] np_eff;
    logic [ssc_pkg::CNT_W-1:0] cnt_dec;
    logic signed [ssc_pkg::Q_W-1:0] emit_score;
    logic signed [ssc_pkg::TOT_W:0] total_sum;

    assign sum_val  = sv_rd_reg ? sum_rd_reg : '0;
    assign dist_q   = ssc_pkg::ONE_Q15 - ((sim_reg > ssc_pkg::ONE_Q15) ? ssc_pkg::ONE_Q15
                                                                        : sim_reg);
    assign sum_add  = {1'b0, sum_val} + (ssc_pkg::SUM_W + 1)'(dist_q);
    assign entry_ok = flag_rd_reg && (col_reg != row_reg);
    assign single   = cnt_rd_reg <= ssc_pkg::CNT_W'(1);
    assign k_use    = (k_reg != lab_rd_reg) && (cnt_rd_reg != '0);
    assign m_val    = (a_reg > b_reg) ? a_reg : b_reg;
    assign diff     = (b_reg >= a_reg) ? (b_reg - a_reg) : (a_reg - b_reg);
    assign total_mag = total_reg[ssc_pkg::TOT_W-1] ? ssc_pkg::TOT_W'(-total_reg)
                                                   : ssc_pkg::TOT_W'(total_reg);
    assign np_eff   = (np_reg == '0) ? ssc_pkg::CNT_W'(1) : np_reg;
    assign cnt_dec  = cnt_rd_reg - 1'b1;
    assign emit_score = (pstat_reg == ssc_pkg::ST_NORMAL) ? score_reg : '0;
    assign total_sum  = (ssc_pkg::TOT_W + 1)'(total_reg) + (ssc_pkg::TOT_W + 1)'(emit_score);

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (cmd.op)
            ssc_pkg::OP_PCHK:
            begin
                div_start = flag_rd_reg && !single;
                div_dvd   = ssc_pkg::DVD_W'(sum_val);
                div_dvs   = ssc_pkg::DVS_W'(cnt_dec);
            end
            ssc_pkg::OP_KCHK:
            begin
                div_start = k_use;
                div_dvd   = ssc_pkg::DVD_W'(sum_val);
                div_dvs   = ssc_pkg::DVS_W'(cnt_rd_reg);
            end
            ssc_pkg::OP_BCHK:
            begin
                div_start = have_b_reg && (m_val != '0);
                div_dvd   = {diff, {ssc_pkg::FRAC_W{1'b0}}};
                div_dvs   = m_val;
            end
            ssc_pkg::OP_FST:
            begin
                div_start = 1'b1;
                div_dvd   = ssc_pkg::DVD_W'(total_mag);
                div_dvs   = ssc_pkg::DVS_W'(np_eff);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        act_next       = act_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        lab_next       = lab_reg;
        sim_next       = sim_reg;
        rend_next      = rend_reg;
        sweep_next     = sweep_reg;
        k_next         = k_reg;
        sv_next        = sv_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        have_b_next    = have_b_reg;
        neg_next       = neg_reg;
        pstat_next     = pstat_reg;
        score_next     = score_reg;
        total_next     = total_reg;
        np_next        = cfg_we ? cfg_data : np_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        res_idx_next   = res_idx_reg;
        res_score_next = res_score_reg;
        res_stat_next  = res_stat_reg;
        pt_re          = 1'b0;
        pt_raddr       = row_reg;
        flag_we        = 1'b0;
        flag_waddr     = row_reg;
        flag_wdata     = 1'b1;
        lab_we         = 1'b0;
        cl_re          = 1'b0;
        cl_raddr       = lab_rd_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = lab_rd_reg;
        cnt_wdata      = '0;
        sum_we         = 1'b0;
        sum_wdata      = '0;
        unique case (cmd.op)
            ssc_pkg::OP_LATCH:
            begin
                act_next   = action;
                row_next   = row_point;
                col_next   = column_point;
                lab_next   = cluster_label;
                sim_next   = similarity;
                rend_next  = row_end;
                sweep_next = '0;
            end
            ssc_pkg::OP_SWEEP:
            begin
                flag_we    = 1'b1;
                flag_waddr = sweep_reg;
                flag_wdata = 1'b0;
                if (sweep_reg < ssc_pkg::PT_W'(NC))
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = sweep_reg[ssc_pkg::CL_W-1:0];
                end
                sv_next    = '0;
                total_next = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            ssc_pkg::OP_RD_ROW:
            begin
                pt_re = 1'b1;
            end
            ssc_pkg::OP_RD_COL:
            begin
                pt_re    = 1'b1;
                pt_raddr = col_reg;
            end
            ssc_pkg::OP_RD_OLD, ssc_pkg::OP_RD_SUM, ssc_pkg::OP_RD_OWN:
            begin
                cl_re = 1'b1;
            end
            ssc_pkg::OP_DEC:
            begin
                if (flag_rd_reg && (cnt_rd_reg != '0))
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_dec;
                end
            end
            ssc_pkg::OP_RD_NEW:
            begin
                cl_re    = 1'b1;
                cl_raddr = lab_reg;
                flag_we  = 1'b1;
                lab_we   = 1'b1;
            end
            ssc_pkg::OP_INC:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = lab_reg;
                cnt_wdata = cnt_rd_reg + 1'b1;
            end
            ssc_pkg::OP_ADD:
            begin
                if (entry_ok)
                begin
                    sum_we    = 1'b1;
                    sum_wdata = sum_add[ssc_pkg::SUM_W] ? ssc_pkg::SUM_MAX
                                                         : sum_add[ssc_pkg::SUM_W-1:0];
                    sv_next[lab_rd_reg] = 1'b1;
                end
            end
            ssc_pkg::OP_PCHK:
            begin
                pstat_next  = single ? ssc_pkg::ST_SINGLE : ssc_pkg::ST_NORMAL;
                have_b_next = 1'b0;
                k_next      = '0;
                // unlabelled row point: no result, sums still cleared
                if (!flag_rd_reg)
                    sv_next = '0;
            end
            ssc_pkg::OP_ADIV:
            begin
                if (div_done)
                    a_next = div_q[ssc_pkg::SUM_W-1:0];
            end
            ssc_pkg::OP_RD_K:
            begin
                cl_re    = 1'b1;
                cl_raddr = k_reg;
            end
            ssc_pkg::OP_KCHK:
            begin
                k_next = k_reg;
            end
            ssc_pkg::OP_KDIV:
            begin
                if (div_done && (!have_b_reg || (div_q[ssc_pkg::SUM_W-1:0] < b_reg)))
                begin
                    b_next      = div_q[ssc_pkg::SUM_W-1:0];
                    have_b_next = 1'b1;
                end
            end
            ssc_pkg::OP_KINC:
            begin
                k_next = k_reg + 1'b1;
            end
            ssc_pkg::OP_BCHK:
            begin
                if (!have_b_reg)
                    pstat_next = ssc_pkg::ST_NO_OTHER;
                score_next = '0;
                neg_next   = b_reg < a_reg;
            end
            ssc_pkg::OP_SDIV:
            begin
                if (div_done)
                    score_next = ssc_pkg::sat_q15(neg_reg, div_q);
            end
            ssc_pkg::OP_EMIT:
            begin
                if (total_sum[ssc_pkg::TOT_W] != total_sum[ssc_pkg::TOT_W-1])
                    total_next = total_sum[ssc_pkg::TOT_W]
                               ? {1'b1, {(ssc_pkg::TOT_W-1){1'b0}}}
                               : {1'b0, {(ssc_pkg::TOT_W-1){1'b1}}};
                else
                    total_next = total_sum[ssc_pkg::TOT_W-1:0];
                res_valid_next = 1'b1;
                res_kind_next  = ssc_pkg::KIND_POINT;
                res_idx_next   = row_reg;
                res_score_next = emit_score;
                res_stat_next  = pstat_reg;
                sv_next        = '0;
            end
            ssc_pkg::OP_FST:
            begin
                neg_next = total_reg[ssc_pkg::TOT_W-1];
            end
            ssc_pkg::OP_FDIV:
            begin
                if (div_done)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = ssc_pkg::KIND_MEAN;
                    res_idx_next   = '0;
                    res_score_next = ssc_pkg::sat_q15(neg_reg, div_q);
                    res_stat_next  = ssc_pkg::ST_NORMAL;
                end
            end
            default:
            begin
                pt_re = 1'b0;
            end
        endcase
    end

    // point memories
    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
        if (lab_we)
            label_mem[row_reg] <= lab_reg;
        if (pt_re)
        begin
            flag_rd_reg <= flag_mem[pt_raddr];
            lab_rd_reg  <= label_mem[pt_raddr];
        end
    end

    // cluster memories
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (sum_we)
            sum_mem[lab_rd_reg] <= sum_wdata;
        if (cl_re)
        begin
            cnt_rd_reg <= cnt_mem[cl_raddr];
            sum_rd_reg <= sum_mem[cl_raddr];
            sv_rd_reg  <= sv_reg[cl_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            k_reg         <= '0;
            sv_reg        <= '0;
            have_b_reg    <= 1'b0;
            pstat_reg     <= ssc_pkg::ST_NORMAL;
            total_reg     <= '0;
            np_reg        <= ssc_pkg::CNT_W'(1);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            k_reg         <= k_next;
            sv_reg        <= sv_next;
            have_b_reg    <= have_b_next;
            pstat_reg     <= pstat_next;
            total_reg     <= total_next;
            np_reg        <= np_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        lab_reg       <= lab_next;
        sim_reg       <= sim_next;
        rend_reg      <= rend_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        neg_reg       <= neg_next;
        score_reg     <= score_next;
        res_kind_reg  <= res_kind_next;
        res_idx_reg   <= res_idx_next;
        res_score_reg <= res_score_next;
        res_stat_reg  <= res_stat_next;
    end

    ssc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.sweep_last = sweep_reg == {ssc_pkg::PT_W{1'b1}};
    assign stat.act        = act_reg;
    assign stat.row_end    = rend_reg;
    assign stat.own_flag   = flag_rd_reg;
    assign stat.single     = single;
    assign stat.k_use      = k_use;
    assign stat.k_last     = k_reg == ssc_pkg::CL_W'(NC - 1);
    assign stat.have_b     = have_b_reg;
    assign stat.m_zero     = m_val == '0;
    assign stat.div_done   = div_done;

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign point_index  = res_idx_reg;
    assign score        = res_score_reg;
    assign status       = res_stat_reg;

endmodule

### rtl/core/ssc_ctrl.sv
// controller state machine sequencing clear, label, entry, row score and finish beats
module ssc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ssc_pkg::stat_t stat,
    output ssc_pkg::cmd_t  cmd,
    output logic           busy
);

    typedef enum logic [20:0] {
        S_CLEAR = 21'h000001,
        S_IDLE  = 21'h000002,
        S_LRD   = 21'h000004,
        S_LOLD  = 21'h000008,
        S_LDEC  = 21'h000010,
        S_LNEW  = 21'h000020,
        S_LINC  = 21'h000040,
        S_ERD   = 21'h000080,
        S_ESUM  = 21'h000100,
        S_EADD  = 21'h000200,
        S_PRD   = 21'h000400,
        S_PCNT  = 21'h000800,
        S_PCHK  = 21'h001000,
        S_ADIV  = 21'h002000,
        S_KRD   = 21'h004000,
        S_KCHK  = 21'h008000,
        S_KDIV  = 21'h010000,
        S_KNEXT = 21'h020000,
        S_BCHK  = 21'h040000,
        S_SDIV  = 21'h080000,
        S_EMIT  = 21'h100000
    } state_t;

    typedef enum logic [2:0] {
        F_NONE = 3'b001,
        F_ST   = 3'b010,
        F_DIV  = 3'b100
    } fin_t;

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd.op     = ssc_pkg::OP_IDLE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = ssc_pkg::OP_SWEEP;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // finish runs on a small side sequence
                unique case (fin_reg)
                    F_ST:
                    begin
                        cmd.op   = ssc_pkg::OP_FST;
                        fin_next = F_DIV;
                    end
                    F_DIV:
                    begin
                        cmd.op = ssc_pkg::OP_FDIV;
                        if (stat.div_done)
                            fin_next = F_NONE;
                    end
                    default:
                    begin
                        if (start)
                        begin
                            cmd.op     = ssc_pkg::OP_LATCH;
                            state_next = S_LRD;
                        end
                    end
                endcase
            end
            S_LRD:
            begin
                unique case (stat.act)
                    ssc_pkg::ACT_CLEAR:  state_next = S_CLEAR;
                    ssc_pkg::ACT_LABEL:
                    begin
                        cmd.op     = ssc_pkg::OP_RD_ROW;
                        state_next = S_LOLD;
                    end
                    ssc_pkg::ACT_ENTRY:
                    begin
                        cmd.op     = ssc_pkg::OP_RD_COL;
                        state_next = S_ESUM;
                    end
                    default:
                    begin
                        fin_next   = F_ST;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOLD:
            begin
                cmd.op     = ssc_pkg::OP_RD_OLD;
                state_next = S_LDEC;
            end
            S_LDEC:
            begin
                cmd.op     = ssc_pkg::OP_DEC;
                state_next = S_LNEW;
            end
            S_LNEW:
            begin
                cmd.op     = ssc_pkg::OP_RD_NEW;
                state_next = S_LINC;
            end
            S_LINC:
            begin
                cmd.op     = ssc_pkg::OP_INC;
                state_next = S_IDLE;
            end
            S_ERD:
            begin
                cmd.op     = ssc_pkg::OP_RD_COL;
                state_next = S_ESUM;
            end
            S_ESUM:
            begin
                cmd.op     = ssc_pkg::OP_RD_SUM;
                state_next = S_EADD;
            end
            S_EADD:
            begin
                cmd.op     = ssc_pkg::OP_ADD;
                state_next = stat.row_end ? S_PRD : S_IDLE;
            end
            S_PRD:
            begin
                cmd.op     = ssc_pkg::OP_RD_ROW;
                state_next = S_PCNT;
            end
            S_PCNT:
            begin
                cmd.op     = ssc_pkg::OP_RD_OWN;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.op = ssc_pkg::OP_PCHK;
                if (!stat.own_flag)
                    state_next = S_IDLE;
                else if (stat.single)
                    state_next = S_EMIT;
                else
                    state_next = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.op = ssc_pkg::OP_ADIV;
                if (stat.div_done)
                    state_next = S_KRD;
            end
            S_KRD:
            begin
                cmd.op     = ssc_pkg::OP_RD_K;
                state_next = S_KCHK;
            end
            S_KCHK:
            begin
                cmd.op     = ssc_pkg::OP_KCHK;
                state_next = stat.k_use ? S_KDIV : S_KNEXT;
            end
            S_KDIV:
            begin
                cmd.op = ssc_pkg::OP_KDIV;
                if (stat.div_done)
                    state_next = S_KNEXT;
            end
            S_KNEXT:
            begin
                cmd.op     = ssc_pkg::OP_KINC;
                state_next = stat.k_last ? S_BCHK : S_KRD;
            end
            S_BCHK:
            begin
                cmd.op = ssc_pkg::OP_BCHK;
                if (!stat.have_b || stat.m_zero)
                    state_next = S_EMIT;
                else
                    state_next = S_SDIV;
            end
            S_SDIV:
            begin
                cmd.op = ssc_pkg::OP_SDIV;
                if (stat.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op     = ssc_pkg::OP_EMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            fin_reg   <= F_NONE;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || (fin_reg != F_NONE);

endmodule

### rtl/core/silhouette_score_engine.sv
// top level of the silhouette score engine
//
// command channel: an item is taken when start is high and busy is low.
// action clear clears labels and zeroes counts, sums and the score total.
// action label updates one point's cluster and both member counts.
// action entry adds 1 - similarity into the column point's cluster sum;
// with row_end set it then scores the row point: one division for a, then a
// walk over all 64 clusters, each nonempty other cluster adding one division,
// then, if b exists and max(a, b) is nonzero, one more division for the score,
// all on the shared divider. a singleton or unlabelled row point ends the row
// without a division. action finish divides the score total by num_points.
// each result beat is shown for one cycle with result_valid high; the
// receiver cannot hold it off. configuration: cfg_data is written to
// num_points when cfg_valid is high; cfg_ready is always high.
// after reset the block runs a clearing pass with busy high, and num_points
// reads 1.
module silhouette_score_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        action,
    input  logic [ssc_pkg::PT_W-1:0]          row_point,
    input  logic [ssc_pkg::PT_W-1:0]          column_point,
    input  logic [ssc_pkg::CL_W-1:0]          cluster_label,
    input  logic [ssc_pkg::SIM_W-1:0]         similarity,
    input  logic                              row_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssc_pkg::CNT_W-1:0]         cfg_data,
    output logic                              result_valid,
    output logic                              result_kind,
    output logic [ssc_pkg::PT_W-1:0]          point_index,
    output logic signed [ssc_pkg::Q_W-1:0]    score,
    output logic [1:0]                        status
);

    ssc_pkg::cmd_t  cmd;
    ssc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    ssc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ssc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .row_point     (row_point),
        .column_point  (column_point),
        .cluster_label (cluster_label),
        .similarity    (similarity),
        .row_end       (row_end),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .point_index   (point_index),
        .score         (score),
        .status        (status)
    );

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result beats in a row");

    a_mean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == ssc_pkg::KIND_MEAN) |->
        (point_index == '0 && status == ssc_pkg::ST_NORMAL))
        else $error("mean result with point index or status set");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ssc_pkg::ST_NORMAL || status == ssc_pkg::ST_SINGLE
                          || status == ssc_pkg::ST_NO_OTHER))
        else $error("undefined status code");

endmodule

### dv/silhouette_score_engine_tb.sv
// self-checking testbench of the silhouette score engine: directed table, then random cluster sets
module silhouette_score_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                           kind;
        logic [ssc_pkg::PT_W-1:0]       idx;
        logic signed [ssc_pkg::Q_W-1:0] val;
        logic [1:0]                     st;
    } score_beat_t;

    typedef struct packed {
        logic [1:0]                act;
        logic [ssc_pkg::PT_W-1:0]  row;
        logic [ssc_pkg::PT_W-1:0]  col;
        logic [ssc_pkg::CL_W-1:0]  lab;
        logic [ssc_pkg::SIM_W-1:0] sim;
        logic                      re;
        logic                      typed;
        logic                      has;
        score_beat_t               beat;
    } dir_row_t;

    logic clk, rst_n, start, busy;
    logic [1:0] action;
    logic [ssc_pkg::PT_W-1:0] row_point, column_point;
    logic [ssc_pkg::CL_W-1:0] cluster_label;
    logic [ssc_pkg::SIM_W-1:0] similarity;
    logic row_end, cfg_valid, cfg_ready;
    logic [ssc_pkg::CNT_W-1:0] cfg_data;
    logic result_valid, result_kind;
    logic [ssc_pkg::PT_W-1:0] point_index;
    logic signed [ssc_pkg::Q_W-1:0] score;
    logic [1:0] status;

    silhouette_score_engine DUT (.*);

    // predictor state
    int unsigned npts_reg;
    logic [ssc_pkg::CL_W-1:0] lab_mem [ssc_pkg::MAX_POINTS];
    bit              lab_ok  [ssc_pkg::MAX_POINTS];
    int unsigned     members [ssc_pkg::MAX_CLUSTERS];
    longint          dist_sum [ssc_pkg::MAX_CLUSTERS];
    longint          total;

    score_beat_t pending_scores[$];
    int errors, n_items, n_points, n_means, n_cfg;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic wipe_model();
        for (int i = 0; i < ssc_pkg::MAX_POINTS; i++) lab_ok[i] = 0;
        for (int k = 0; k < ssc_pkg::MAX_CLUSTERS; k++)
        begin
            members[k] = 0;
            dist_sum[k] = 0;
        end
        total = 0;
    endtask

    task automatic score_point(input int p, output bit got, output score_beat_t b);
        int own;
        int unsigned n;
        longint a, bmin, m, avg, sc;
        bit have_b;
        got = 0;
        b = '0;
        sc = 0;
        have_b = 0;
        bmin = 0;
        if (!lab_ok[p]) return;
        got = 1;
        b.kind = ssc_pkg::KIND_POINT;
        b.idx = ssc_pkg::PT_W'(p);
        own = int'(lab_mem[p]);
        n = members[own];
        if (n <= 1)
        begin
            b.st = ssc_pkg::ST_SINGLE;
            return;
        end
        a = dist_sum[own] / longint'(n - 1);
        for (int k = 0; k < ssc_pkg::MAX_CLUSTERS; k++)
        begin
            if (k == own || members[k] == 0) continue;
            avg = dist_sum[k] / longint'(members[k]);
            if (!have_b || avg < bmin)
            begin
                bmin = avg;
                have_b = 1;
            end
        end
        if (!have_b)
        begin
            b.st = ssc_pkg::ST_NO_OTHER;
            return;
        end
        b.st = ssc_pkg::ST_NORMAL;
        m = a > bmin ? a : bmin;
        if (m > 0) sc = clip16(((bmin - a) * 32768) / m);
        b.val = sc[15:0];
    endtask

    task automatic predict_score(input logic [1:0] act, input int row, input int col,
                                 input int lab, input int sim, input bit re,
                                 output bit got, output score_beat_t b);
        int c;
        longint s, d;
        got = 0;
        b = '0;
        case (act)
            ssc_pkg::ACT_CLEAR: wipe_model();
            ssc_pkg::ACT_LABEL:
            begin
                if (lab_ok[row] && members[lab_mem[row]] > 0) members[lab_mem[row]]--;
                lab_mem[row] = ssc_pkg::CL_W'(lab);
                lab_ok[row] = 1;
                members[lab]++;
            end
            ssc_pkg::ACT_ENTRY:
            begin
                if (col != row && lab_ok[col])
                begin
                    c = int'(lab_mem[col]);
                    s = dist_sum[c] + 32768 - (sim > 32768 ? 32768 : sim);
                    dist_sum[c] = s > 67108863 ? 67108863 : s;
                end
                if (re)
                begin
                    score_point(row, got, b);
                    for (int k = 0; k < ssc_pkg::MAX_CLUSTERS; k++) dist_sum[k] = 0;
                    if (got)
                    begin
                        total += b.val;
                        if (total > 67108863) total = 67108863;
                        if (total < -67108864) total = -67108864;
                    end
                end
            end
            default:
            begin
                d = npts_reg == 0 ? 1 : npts_reg;
                s = clip16(total / d);
                got = 1;
                b.kind = ssc_pkg::KIND_MEAN;
                b.val = s[15:0];
            end
        endcase
    endtask

    // one command beat; enters and leaves at a falling edge
    task automatic send_cmd(input logic [1:0] act, input int row, input int col,
                            input int lab, input int sim, input bit re,
                            input bit typed = 0, input bit has = 0,
                            input score_beat_t tb = '0);
        int gap, r;
        bit got;
        score_beat_t b;
        r = $urandom_range(0, 99);
        gap = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60));
        if (gap > 0)
        begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
        action = act;
        row_point = ssc_pkg::PT_W'(row);
        column_point = ssc_pkg::PT_W'(col);
        cluster_label = ssc_pkg::CL_W'(lab);
        similarity = ssc_pkg::SIM_W'(sim);
        row_end = re;
        start = 1;
        do @(posedge clk); while (busy);
        predict_score(action, int'(row_point), int'(column_point), int'(cluster_label),
                      int'(similarity), row_end, got, b);
        if (typed)
        begin
            got = has;
            b = tb;
        end
        if (got) pending_scores = {pending_scores, b};
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        start = 0;
        while (pending_scores.size() != 0) @(negedge clk);
    endtask

    // register write only with the block idle; a clear may still be running
    task automatic write_npts(input int v);
        drain();
        repeat (1100) @(negedge clk);
        cfg_data = ssc_pkg::CNT_W'(v);
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        npts_reg = int'(cfg_data);
        n_cfg++;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    always @(posedge clk)
    begin
        score_beat_t e;
        if (rst_n && result_valid)
        begin
            if (pending_scores.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                e = pending_scores.pop_front();
                if (result_kind === ssc_pkg::KIND_MEAN) n_means++; else n_points++;
                if (result_kind !== e.kind)
                    report($sformatf("kind %b exp %b", result_kind, e.kind));
                if (point_index !== e.idx)
                    report($sformatf("point_index %0d exp %0d", point_index, e.idx));
                if (score !== e.val)
                    report($sformatf("score %0d exp %0d (pt %0d)", score, e.val, e.idx));
                if (status !== e.st)
                    report($sformatf("status %0d exp %0d (pt %0d)", status, e.st, e.idx));
            end
        end
    end

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("timeout");
        $display("FAIL silhouette_score_engine");
        $finish;
    end

    localparam int DIR_N = 26;
    dir_row_t dir_tab [DIR_N];

    // one labelled set: clear, label, optional relabel, rows, finish, optional label
    task automatic run_set(input bit big_row);
        int n, nc, tries, v, r;
        int pts[$];
        int clus[$];
        n = big_row ? 3 : $urandom_range(2, 8);
        nc = $urandom_range(1, 4);
        send_cmd(ssc_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        for (int k = 0; k < nc; k++) clus = {clus, int'($urandom_range(0, 63))};
        while (pts.size() < n)
        begin
            v = $urandom_range(0, 1023);
            tries = 0;
            foreach (pts[j]) if (pts[j] == v) tries = 1;
            if (!tries) pts = {pts, v};
        end
        foreach (pts[j])
            send_cmd(ssc_pkg::ACT_LABEL, pts[j], $urandom, big_row ? (j == 0 ? 1 : 2) :
                     clus[$urandom_range(0, nc - 1)], $urandom, 1'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_cmd(ssc_pkg::ACT_LABEL, pts[$urandom_range(0, n - 1)], $urandom,
                     clus[$urandom_range(0, nc - 1)], $urandom, 1'($urandom));
        if (big_row)
        begin
            // long row of entries before its row end
            for (int i = 0; i < 300; i++)
                send_cmd(ssc_pkg::ACT_ENTRY, pts[0], pts[1 + i % 2], 0, 0, 0);
            send_cmd(ssc_pkg::ACT_ENTRY, pts[0], pts[1], 0, $urandom_range(0, 32768), 1);
        end
        else
            foreach (pts[i])
            begin
                for (int j = 0; j < n; j++)
                begin
                    r = $urandom_range(0, 19);
                    v = r == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
                    send_cmd(ssc_pkg::ACT_ENTRY, pts[i],
                             r == 1 ? $urandom_range(0, 1023) : pts[j],
                             $urandom, v, j == n - 1);
                end
                if ($urandom_range(0, 9) == 0)
                    send_cmd(ssc_pkg::ACT_ENTRY, $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom,
                             $urandom_range(0, 65535), 1'($urandom));
            end
        send_cmd(ssc_pkg::ACT_FINISH, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        if ($urandom_range(0, 2) == 0)
            send_cmd(ssc_pkg::ACT_LABEL, $urandom_range(0, 1023), $urandom,
                     $urandom_range(0, 63), $urandom, 1'($urandom));
    endtask

    initial
    begin
        int sets;
        start = 0;
        action = ssc_pkg::ACT_CLEAR;
        row_point = 0;
        column_point = 0;
        cluster_label = 0;
        similarity = 0;
        row_end = 0;
        cfg_valid = 0;
        cfg_data = 0;
        rst_n = 0;
        npts_reg = 1;
        wipe_model();
        dir_tab = '{
            '{ssc_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 1, 1,
              '{ssc_pkg::KIND_MEAN, 0, 0, ssc_pkg::ST_NORMAL}},
            '{ssc_pkg::ACT_LABEL, 5, 0, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 5, 0, 0, 1, 1, 1,
              '{ssc_pkg::KIND_POINT, 5, 0, ssc_pkg::ST_SINGLE}},
            '{ssc_pkg::ACT_LABEL, 6, 0, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 6, 0, 0, 1, 1, 1,
              '{ssc_pkg::KIND_POINT, 5, 0, ssc_pkg::ST_NO_OTHER}},
            '{ssc_pkg::ACT_LABEL, 7, 0, 63, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_LABEL, 1023, 0, 63, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 6, 0, 32768, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 7, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 1023, 0, 0, 1, 1, 1,
              '{ssc_pkg::KIND_POINT, 5, 32767, ssc_pkg::ST_NORMAL}},
            '{ssc_pkg::ACT_ENTRY, 7, 1023, 0, 65535, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 7, 5, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 7, 6, 0, 0, 1, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 6, 5, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 6, 7, 0, 65535, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 6, 1023, 0, 65535, 1, 1, 1,
              '{ssc_pkg::KIND_POINT, 6, -32768, ssc_pkg::ST_NORMAL}},
            '{ssc_pkg::ACT_ENTRY, 5, 6, 0, 32768, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 7, 0, 32768, 1, 1, 1,
              '{ssc_pkg::KIND_POINT, 5, 0, ssc_pkg::ST_NORMAL}},
            '{ssc_pkg::ACT_ENTRY, 100, 5, 0, 0, 1, 1, 0, '0},
            '{ssc_pkg::ACT_LABEL, 6, 0, 1, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 6, 0, 1000, 0, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 1023, 0, 20000, 1, 0, 0, '0},
            '{ssc_pkg::ACT_ENTRY, 5, 512, 0, 300, 1, 0, 0, '0},
            '{ssc_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0},
            '{ssc_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 1, 1,
              '{ssc_pkg::KIND_MEAN, 0, 0, ssc_pkg::ST_NORMAL}}
        };
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        foreach (dir_tab[i])
            send_cmd(dir_tab[i].act, dir_tab[i].row, dir_tab[i].col, dir_tab[i].lab,
                     dir_tab[i].sim, dir_tab[i].re, dir_tab[i].typed, dir_tab[i].has,
                     dir_tab[i].beat);
        sets = 0;
        while (n_items < 1125)
        begin
            if (sets % 5 == 0)
            begin
                case ((sets / 5) % 5)
                    0: write_npts(0);
                    1: write_npts(2047);
                    2: write_npts(1);
                    3: write_npts($urandom_range(0, 2047));
                    default: write_npts($urandom_range(1, 8));
                endcase
            end
            else if (sets % 7 == 3)
                drain();
            run_set(sets == 4);
            sets++;
        end
        start = 0;
        while (pending_scores.size() != 0) @(negedge clk);
        repeat (3000) @(negedge clk);
        if (pending_scores.size() != 0)
            report($sformatf("%0d results never arrived", pending_scores.size()));
        $display("covered %0d commands in %0d sets, %0d register writes", n_items, sets, n_cfg);
        $display("checked %0d point scores and %0d mean scores", n_points, n_means);
        if (errors == 0)
            $display("PASS silhouette_score_engine");
        else
            $display("FAIL silhouette_score_engine");
        $finish;
    end

endmodule
